>>> hw/rtl/rscst_pkg.sv
`timescale 1ns / 1ps
package rscst_pkg;
	localparam int unsigned MaxLinesDefault = 65536;
	localparam int unsigned LineCountW = 17;
	localparam int unsigned SeedW = 64;
	localparam int unsigned IndexW = 16;
	localparam int unsigned OffsetW = 22;
	localparam int unsigned StatusW = 2;
	localparam logic [63:0] GoldenGamma = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MixMulA = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MixMulB = 64'h94d049bb133111eb;
	localparam logic [63:0] SeedReset = 64'h0000_0000_00C0_FFEE;
	localparam logic [LineCountW-1:0] LineCountReset = 17'd65536;
	localparam logic OpBuild = 1'b0;
	localparam logic OpLookup = 1'b1;
	localparam logic [StatusW-1:0] StOk = 2'd0;
	localparam logic [StatusW-1:0] StRange = 2'd1;
	localparam logic [StatusW-1:0] StNotBuilt = 2'd2;
	localparam logic CfgLineCount = 1'b0;
	localparam logic CfgSeed = 1'b1;
endpackage

>>> hw/rtl/rscst_mul32.sv
`timescale 1ns / 1ps
// 64x64 low-half multiplier built from 32x32 partial products, accumulated in sequence.
module rscst_mul32 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);
	logic [63:0] a_q, b_q, acc_q;
	logic [2:0]  step_q;
	logic        busy_q;
	logic [63:0] pp;
	logic [31:0] x, y;

	// Select the partial product of this step.
	always_comb begin
		x = a_q[31:0];
		y = b_q[31:0];
		case (step_q)
			3'd1: begin x = a_q[63:32]; y = b_q[31:0]; end
			3'd2: begin x = a_q[31:0]; y = b_q[63:32]; end
			default: begin x = a_q[31:0]; y = b_q[31:0]; end
		endcase
		pp = {32'd0, x} * {32'd0, y};
	end

	// Accumulate the three products that reach the low half.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
				a_q    <= a;
				b_q    <= b;
			end else if (busy_q) begin
				if (step_q == 3'd0) acc_q <= pp;
				else acc_q <= acc_q + {pp[31:0], 32'd0};
				if (step_q == 3'd2) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				step_q <= step_q + 3'd1;
			end
		end
	end
	assign p = acc_q;
endmodule

>>> hw/rtl/rscst_divider.sv
`timescale 1ns / 1ps
// Restoring remainder of a 64-bit value by a narrow divisor, one bit per cycle.
module rscst_divider #(
	parameter int unsigned W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] rem
);
	logic [63:0] num_q;
	logic [W:0]  rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [W:0]  shifted;

	assign shifted = {rem_q[W-1:0], num_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				num_q  <= dividend;
				rem_q  <= '0;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				num_q <= {num_q[62:0], 1'b0};
				if (shifted >= {1'b0, divisor}) rem_q <= shifted - {1'b0, divisor};
				else rem_q <= shifted;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end
	assign rem = rem_q[W-1:0];
endmodule

>>> hw/rtl/random_single_cycle_successor_table.sv
`timescale 1ns / 1ps
// Lookup: the output register loads at the edge after acceptance. The next item is taken no
// earlier than the edge that takes that result, so one lookup is in flight at a time.
// Build: fills n lines, then n - 1 shuffle steps (two multiplies, a remainder, a read and two
// writes each), then the successor chain; a one-line build skips the shuffle steps.
// Reset clears control state, registers to their reset values; table memories are
// left undefined and are only read after the build that wrote them.
module random_single_cycle_successor_table #(
	parameter int unsigned MAX_LINES = rscst_pkg::MaxLinesDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [rscst_pkg::SeedW-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        operation,
	input  logic [rscst_pkg::IndexW-1:0] line_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rscst_pkg::OffsetW-1:0] next_offset,
	output logic [rscst_pkg::StatusW-1:0] status
);
	import rscst_pkg::*;

	localparam int unsigned AW = (MAX_LINES > 2) ? $clog2(MAX_LINES) : 1;
	localparam int unsigned CW = AW + 1;

	localparam logic [3:0] S_IDLE = 4'd0, S_FILL = 4'd1, S_RNG = 4'd2, S_MA = 4'd3,
		S_MB = 4'd4, S_DIV = 4'd5, S_RD = 4'd6, S_WR = 4'd7, S_CH0 = 4'd8,
		S_CH = 4'd9, S_DONE = 4'd10, S_WR2 = 4'd11, S_CHL = 4'd12;

	logic [3:0] st_q;
	logic [LineCountW-1:0] line_count_q;
	logic [SeedW-1:0] seed_q, rng_q;
	logic built_q;
	logic [CW-1:0] n_q, bcount_q;
	logic [AW-1:0] i_q, j_q, first_q, prev_q;

	// Memories.
	logic [AW-1:0] perm_mem [MAX_LINES];
	logic [AW-1:0] succ_mem [MAX_LINES];
	logic [AW-1:0] pa_rd_s1, pb_rd_s1, succ_rd_s1;
	logic          pw_we;
	logic [AW-1:0] pa_addr, pb_addr, pw_addr, pw_wd;
	logic          sc_we;
	logic [AW-1:0] sc_waddr, sc_wd, sc_raddr;

	// Arithmetic units.
	logic          mul_start, mul_done, div_start, div_done;
	logic [63:0]   mul_a, mul_b, mul_p;
	logic [AW-1:0] div_rem;
	logic [63:0]   z_mix;

	rscst_mul32 u_mul (.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p));
	rscst_divider #(.W(AW)) u_div (.clk, .arst_n, .start(div_start), .dividend(z_mix),
		.divisor(i_q), .done(div_done), .rem(div_rem));

	logic out_free, lk_acc, bd_acc;
	logic lk_s1;
	logic [StatusW-1:0] lst_s1;
	logic [CW-1:0] clamp;
	assign out_free  = !out_valid || out_ready;
	assign in_ready  = (st_q == S_IDLE) && !lk_s1 && out_free;
	assign cfg_ready = (st_q == S_IDLE);
	assign lk_acc    = in_valid && in_ready && (operation == OpLookup);
	assign bd_acc    = in_valid && in_ready && (operation == OpBuild);

	// Clamp line_count into 1..MAX_LINES.
	always_comb begin
		if (line_count_q == '0) clamp = CW'(1);
		else if ({15'd0, line_count_q} > 32'(MAX_LINES)) clamp = CW'(MAX_LINES);
		else clamp = CW'(line_count_q);
	end

	// Operands of the two mixing multiplies; the remainder starts on the final mix.
	always_comb begin
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = MixMulA;
		div_start = 1'b0;
		case (st_q)
			S_RNG: begin
				mul_start = 1'b1;
				mul_a = (rng_q + GoldenGamma) ^ ((rng_q + GoldenGamma) >> 30);
			end
			S_MA: begin
				mul_start = mul_done;
				mul_a = mul_p ^ (mul_p >> 27);
				mul_b = MixMulB;
			end
			default: ;
		endcase
		z_mix = mul_p ^ (mul_p >> 31);
		if (st_q == S_MB && mul_done) div_start = 1'b1;
	end

	// Memory port control. The swap writes its two entries one after the other, in S_WR and S_WR2.
	always_comb begin
		pw_we = 1'b0;
		pa_addr = i_q; pb_addr = j_q;
		pw_addr = i_q; pw_wd = i_q;
		sc_we = 1'b0; sc_waddr = prev_q; sc_wd = pa_rd_s1;
		sc_raddr = AW'(line_index);
		case (st_q)
			S_FILL: pw_we = 1'b1;
			S_WR: begin
				pw_we = 1'b1;
				pw_wd = pb_rd_s1;
			end
			S_WR2: begin
				pw_we = 1'b1;
				pw_addr = j_q;
				pw_wd = pa_rd_s1;
			end
			S_CH: begin
				// The first pass only captures perm[0]; there is no predecessor yet.
				sc_we = (i_q != AW'(1));
				sc_waddr = prev_q;
				sc_wd = pa_rd_s1;
			end
			S_CHL: begin
				sc_we = 1'b1;
				sc_waddr = prev_q;
				sc_wd = pa_rd_s1;
			end
			S_DONE: begin
				sc_we = 1'b1;
				sc_waddr = prev_q;
				sc_wd = first_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pw_we) perm_mem[pw_addr] <= pw_wd;
		pa_rd_s1 <= perm_mem[pa_addr];
		pb_rd_s1 <= perm_mem[pb_addr];
	end
	always_ff @(posedge clk) begin
		if (sc_we) succ_mem[sc_waddr] <= sc_wd;
		succ_rd_s1 <= succ_mem[sc_raddr];
	end

	// Sequencer and registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			line_count_q <= LineCountReset;
			seed_q <= SeedReset;
			rng_q <= '0;
			built_q <= 1'b0;
			bcount_q <= '0;
			out_valid <= 1'b0;
			lk_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CfgLineCount) line_count_q <= cfg_data[LineCountW-1:0];
				else seed_q <= cfg_data;
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			lk_s1 <= lk_acc;
			if (lk_acc) begin
				if (!built_q) lst_s1 <= StNotBuilt;
				else if (32'(line_index) >= 32'(bcount_q)) lst_s1 <= StRange;
				else lst_s1 <= StOk;
			end
			if (lk_s1) begin
				out_valid <= 1'b1;
				status <= lst_s1;
				next_offset <= (lst_s1 == StOk) ? OffsetW'({succ_rd_s1, 6'd0}) : '0;
			end
			case (st_q)
				S_IDLE: if (bd_acc) begin
					n_q <= clamp;
					rng_q <= seed_q;
					i_q <= '0;
					st_q <= S_FILL;
				end
				S_FILL: begin
					if (CW'(i_q) == n_q - CW'(1)) begin
						if (n_q == CW'(1)) begin
							i_q <= '0;
							st_q <= S_CH0;
						end else st_q <= S_RNG;
					end else i_q <= i_q + AW'(1);
				end
				S_RNG: begin
					rng_q <= rng_q + GoldenGamma;
					st_q <= S_MA;
				end
				S_MA: if (mul_done) st_q <= S_MB;
				S_MB: if (mul_done) st_q <= S_DIV;
				S_DIV: if (div_done) begin
					j_q <= div_rem;
					st_q <= S_RD;
				end
				S_RD: st_q <= S_WR;
				S_WR: st_q <= S_WR2;
				S_WR2: begin
					if (i_q == AW'(1)) begin
						i_q <= '0;
						st_q <= S_CH0;
					end else begin
						i_q <= i_q - AW'(1);
						st_q <= S_RNG;
					end
				end
				S_CH0: begin
					// pa reads perm[0]; next cycle captures it.
					i_q <= AW'(1);
					st_q <= (n_q == CW'(1)) ? S_DONE : S_CH;
				end
				S_CH: begin
					if (CW'(i_q) == CW'(1)) first_q <= pa_rd_s1;
					prev_q <= pa_rd_s1;
					if (CW'(i_q) == n_q - CW'(1)) st_q <= S_CHL;
					else i_q <= i_q + AW'(1);
				end
				S_CHL: begin
					prev_q <= pa_rd_s1;
					st_q <= S_DONE;
				end
				S_DONE: begin
					built_q <= 1'b1;
					bcount_q <= n_q;
					out_valid <= 1'b1;
					status <= StOk;
					next_offset <= '0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
			if (st_q == S_CH0 && n_q == CW'(1)) begin
				first_q <= '0;
				prev_q <= '0;
			end
		end
	end
endmodule

>>> verif/random_single_cycle_successor_table_checker.sv
`timescale 1ns / 1ps
module random_single_cycle_successor_table_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [rscst_pkg::SeedW-1:0]    cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           operation,
	input  logic [rscst_pkg::IndexW-1:0]   line_index,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [rscst_pkg::OffsetW-1:0]  next_offset,
	input  logic [rscst_pkg::StatusW-1:0]  status,
	output int                             mismatches,
	output int                             pending
);
	import rscst_pkg::*;

	// Shadow copy of the registers and the tables.
	logic [LineCountW-1:0] line_count_reg;
	logic [SeedW-1:0]      seed_reg;
	logic [63:0]           gen_state;
	logic [15:0]           order [MaxLinesDefault];
	logic [15:0]           succ [MaxLinesDefault];
	bit                    have_cycle;
	int unsigned           cycle_len;

	// Expected results, oldest first.
	logic [OffsetW-1:0] exp_offset_q[$];
	logic [StatusW-1:0] exp_status_q[$];

	// One splitmix64 draw.
	function automatic logic [63:0] mix_step();
		logic [63:0] z;
		gen_state = gen_state + GoldenGamma;
		z = gen_state;
		z = (z ^ (z >> 30)) * MixMulA;
		z = (z ^ (z >> 27)) * MixMulB;
		return z ^ (z >> 31);
	endfunction

	// Sattolo shuffle over the lines in use, then the successor chain.
	task automatic shuffle_lines();
		int unsigned n;
		int unsigned j;
		logic [15:0] t;
		logic [63:0] r;
		n = line_count_reg;
		if (n < 1) n = 1;
		if (n > MaxLinesDefault) n = MaxLinesDefault;
		gen_state = seed_reg;
		for (int unsigned i = 0; i < n; i++) order[i] = i[15:0];
		for (int unsigned i = n - 1; i > 0; i--) begin
			r = mix_step();
			j = int'(r % 64'(i));
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int unsigned i = 0; i < n; i++) begin
			succ[order[i]] = order[(i + 1 == n) ? 0 : i + 1];
		end
		cycle_len = n;
		have_cycle = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [OffsetW-1:0] eo;
		logic [StatusW-1:0] es;
		if (!arst_n) begin
			line_count_reg = LineCountReset;
			seed_reg = SeedReset;
			have_cycle = 1'b0;
			cycle_len = 0;
			gen_state = '0;
			mismatches = 0;
			pending = 0;
			exp_offset_q.delete();
			exp_status_q.delete();
		end else begin
			// Results are compared before new items are predicted.
			if (out_valid && out_ready) begin
				if (exp_offset_q.size() == 0) begin
					$error("result with no item outstanding: next_offset %0d status %0d",
						next_offset, status);
					mismatches = mismatches + 1;
				end else begin
					eo = exp_offset_q.pop_front();
					es = exp_status_q.pop_front();
					if (next_offset !== eo) begin
						$error("next_offset: expected %0d, actual %0d", eo, next_offset);
						mismatches = mismatches + 1;
					end
					if (status !== es) begin
						$error("status: expected %0d, actual %0d", es, status);
						mismatches = mismatches + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CfgLineCount) line_count_reg = cfg_data[LineCountW-1:0];
				else seed_reg = cfg_data;
			end
			if (in_valid && in_ready) begin
				eo = '0;
				es = StOk;
				if (operation == OpBuild) shuffle_lines();
				else if (!have_cycle) es = StNotBuilt;
				else if (line_index >= cycle_len) es = StRange;
				else eo = OffsetW'({succ[line_index], 6'd0});
				exp_offset_q.push_back(eo);
				exp_status_q.push_back(es);
			end
			pending = exp_offset_q.size();
		end
	end
endmodule

>>> verif/random_single_cycle_successor_table_tb.sv
`timescale 1ns / 1ps
module random_single_cycle_successor_table_tb;
	import rscst_pkg::*;

	localparam int StallLimit = 400000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_index = CfgLineCount;
	logic [SeedW-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                operation = OpLookup;
	logic [IndexW-1:0]   line_index = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [OffsetW-1:0]  next_offset;
	logic [StatusW-1:0]  status;
	int                  mismatches;
	int                  pending;

	int          send_idle_pct = 13;
	int          recv_idle_pct = 85;
	bit          hold_req = 1'b0;
	int unsigned lines_built = 0;
	int          quiet_cycles = 0;

	always #6 clk = ~clk;

	random_single_cycle_successor_table uut (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .operation, .line_index,
		.out_valid, .out_ready, .next_offset, .status
	);

	random_single_cycle_successor_table_checker chk (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .operation, .line_index,
		.out_valid, .out_ready, .next_offset, .status,
		.mismatches, .pending
	);

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog on cycles where no channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_item(input logic op, input logic [IndexW-1:0] idx);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		line_index <= idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Waits for every outstanding result, and a little more for the block to settle.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [SeedW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic rebuild(input int unsigned lines, input logic [SeedW-1:0] sd);
		wait_idle();
		write_reg(CfgLineCount, SeedW'(lines));
		write_reg(CfgSeed, sd);
		send_item(OpBuild, IndexW'($urandom));
		lines_built = (lines < 1) ? 1 : ((lines > 65536) ? 65536 : lines);
	endtask

	task automatic random_lookup();
		if ($urandom_range(99) < 80)
			send_item(OpLookup, IndexW'($urandom_range(lines_built - 1)));
		else
			send_item(OpLookup, IndexW'($urandom));
	endtask

	task automatic random_phase(input int items);
		for (int k = 0; k < items; k++) begin
			if (k % 25 == 0)
				rebuild($urandom_range(48, 2), {$urandom, $urandom});
			else if ($urandom_range(99) < 4)
				send_item(OpBuild, IndexW'($urandom));
			else
				random_lookup();
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: lookups before any build.
		send_item(OpLookup, 16'd0);
		send_item(OpLookup, 16'hFFFF);
		// Single line: line 0 is its own successor.
		rebuild(1, 64'd0);
		send_item(OpLookup, 16'd0);
		send_item(OpLookup, 16'd1);
		send_item(OpLookup, 16'hFFFF);
		rebuild(2, '1);
		send_item(OpLookup, 16'd0);
		send_item(OpLookup, 16'd1);
		send_item(OpLookup, 16'd2);
		// A zero count is taken as one line.
		rebuild(0, SeedReset);
		send_item(OpLookup, 16'd0);
		send_item(OpLookup, 16'd1);
		rebuild(1000, {$urandom, $urandom});
		send_item(OpLookup, 16'd999);
		send_item(OpLookup, 16'd0);
		send_item(OpLookup, 16'd1000);
		// Count changed after a build: the latched count still rules.
		wait_idle();
		write_reg(CfgLineCount, SeedW'(65536));
		send_item(OpLookup, 16'd500);
		send_item(OpLookup, 16'd999);
		send_item(OpLookup, 16'd1000);
		send_item(OpLookup, 16'hFFFF);

		// Random: three idling phases.
		random_phase(150);
		wait_idle();
		send_idle_pct = 85;
		recv_idle_pct = 13;
		random_phase(150);
		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(120);
		// Long receiver hold-off while lookups keep coming.
		hold_req = 1'b1;
		for (int k = 0; k < 30; k++) random_lookup();

		wait_idle();
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
